FILE: src/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection unit.
`timescale 1ns / 1ps
package rti_pkg;

  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int MA_W     = 2 * EDGE_W + 2;
  localparam int MB_W     = EDGE_W + 1;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int DOT_W    = PROD_W;
  localparam int DET_W    = DOT_W - 1;
  localparam int NUM_W    = DOT_W + FRAC_W;
  localparam int QUO_W    = 32;
  localparam int DSH_W    = DET_W + QUO_W;
  localparam int MUL_LAT  = 5;
  localparam int NMUL     = 12;
  localparam int CHUNK_A  = 23;
  localparam int CHUNK_B  = 17;
  localparam int NCHUNK_A = 3;
  localparam int NCHUNK_B = 2;
  localparam int NFIELD   = 9;

  localparam logic [COORD_W-1:0] REG_RESET_DIR_Z = COORD_W'(1) << FRAC_W;
  localparam logic [31:0] REG_RESET_LIMIT        = 32'd2814750;
  localparam logic [31:0] MISS_DIST              = ~((32'd1 << FRAC_W) - 32'd1);
  localparam logic [31:0] DIST_MAX               = {1'b0, {31{1'b1}}};
  localparam logic [31:0] DIST_MIN               = {1'b1, 31'd0};

  typedef enum logic [2:0] {
    CFG_ORIGIN_X       = 3'd0,
    CFG_ORIGIN_Y       = 3'd1,
    CFG_ORIGIN_Z       = 3'd2,
    CFG_DIRECTION_X    = 3'd3,
    CFG_DIRECTION_Y    = 3'd4,
    CFG_DIRECTION_Z    = 3'd5,
    CFG_PARALLEL_LIMIT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [EDGE_W-1:0] x;
    logic signed [EDGE_W-1:0] y;
    logic signed [EDGE_W-1:0] z;
  } evec_t;

  typedef struct packed {
    evec_t e1;
    evec_t e2;
    evec_t s;
  } edges_t;

  typedef struct packed {
    logic signed [MA_W-1:0] x;
    logic signed [MA_W-1:0] y;
    logic signed [MA_W-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic               miss;
    logic               tneg;
    logic               ovf;
    logic [NUM_W-1:0]   rem;
    logic [DET_W-1:0]   det;
    logic [QUO_W-1:0]   quo;
  } div_t;

endpackage

FILE: src/ray_triangle_intersect_top.sv
// Top level of the ray/triangle intersection unit.
`timescale 1ns / 1ps
// Moller-Trumbore ray/triangle test in exact fixed point. Write the ray origin,
// direction and parallel limit through the cfg port while the unit is idle, then
// stream triangles in. One item per clock is taken while the skid register is empty.
// The 49 register stages are: an edge stage, two rounds of a 5-stage multiplier (cross
// products, then dot products) each closed by a sum stage, a sign-normalise stage, a
// compare stage, an overflow check, a 32-stage restoring divider that yields one quotient
// bit per stage, and an output register. A waiting result sits
// in a one-entry skid register, so input is still taken in the cycle the output first
// stalls. Input is then held off while the skid register is full, including the cycle
// in which it drains. On a miss, hit is 0 and distance reads -1.0; negative distances
// are reported as hits.
module ray_triangle_intersect_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [287:0]  s_axis_tdata,   // a_x a_y a_z b_x b_y b_z c_x c_y c_z, 32 bits each
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,   // distance
  output logic          m_axis_tuser,   // hit
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import rti_pkg::*;

  logic en;
  logic signed [COORD_W-1:0] fld [NFIELD];
  logic signed [COORD_W-1:0] org_x_q, org_y_q, org_z_q, dir_x_q, dir_y_q, dir_z_q;
  logic [31:0] lim_q;

  edges_t st1_d, st1_q;
  logic   v1_q;
  edges_t dly_q [MUL_LAT];
  logic [MUL_LAT-1:0] v1d_q;

  logic signed [MA_W-1:0]   m1_a [NMUL];
  logic signed [MB_W-1:0]   m1_b [NMUL];
  logic signed [PROD_W-1:0] m1_p [NMUL];
  logic signed [MA_W-1:0]   m2_a [NMUL];
  logic signed [MB_W-1:0]   m2_b [NMUL];
  logic signed [PROD_W-1:0] m2_p [NMUL];

  cvec_t  p_q, q_q;
  edges_t xe_q;
  logic   xv_q;
  logic [MUL_LAT-1:0] v2d_q;

  logic signed [DOT_W-1:0] det_q, u_q, v_q, t_q;
  logic dv_q;

  logic signed [DOT_W-1:0] det_s, u_s, v_s, t_s;
  logic [DET_W-1:0] detn_q;
  logic signed [DOT_W-1:0] un_q, vn_q, tn_q;
  logic par_miss_q, nv_q;

  logic signed [DOT_W:0] det_x, uv_sum;
  logic [DOT_W-1:0] t_abs;
  logic c_miss_q, c_tneg_q, cv_q;
  logic [NUM_W-1:0] c_num_q;
  logic [DET_W-1:0] c_det_q;

  div_t div_q [QUO_W+1];
  logic [QUO_W:0] div_v_q;
  div_t div_last;

  logic [31:0] dist_d;
  logic res_v_q, res_hit_q;
  logic [31:0] res_dist_q;
  logic skid_v_q, skid_hit_q;
  logic [31:0] skid_dist_q;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  for (genvar f = 0; f < NFIELD; f++) begin : g_fld
    assign fld[f] = $signed(s_axis_tdata[f*COORD_W +: COORD_W]);
  end

  // ray registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= $signed(REG_RESET_DIR_Z);
      lim_q   <= REG_RESET_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ORIGIN_X:       org_x_q <= $signed(cfg_data_i);
        CFG_ORIGIN_Y:       org_y_q <= $signed(cfg_data_i);
        CFG_ORIGIN_Z:       org_z_q <= $signed(cfg_data_i);
        CFG_DIRECTION_X:    dir_x_q <= $signed(cfg_data_i);
        CFG_DIRECTION_Y:    dir_y_q <= $signed(cfg_data_i);
        CFG_DIRECTION_Z:    dir_z_q <= $signed(cfg_data_i);
        CFG_PARALLEL_LIMIT: lim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // edges: e1 = b - a, e2 = c - a, s = origin - a
  always_comb begin
    st1_d.e1.x = EDGE_W'(fld[3]) - EDGE_W'(fld[0]);
    st1_d.e1.y = EDGE_W'(fld[4]) - EDGE_W'(fld[1]);
    st1_d.e1.z = EDGE_W'(fld[5]) - EDGE_W'(fld[2]);
    st1_d.e2.x = EDGE_W'(fld[6]) - EDGE_W'(fld[0]);
    st1_d.e2.y = EDGE_W'(fld[7]) - EDGE_W'(fld[1]);
    st1_d.e2.z = EDGE_W'(fld[8]) - EDGE_W'(fld[2]);
    st1_d.s.x  = EDGE_W'(org_x_q) - EDGE_W'(fld[0]);
    st1_d.s.y  = EDGE_W'(org_y_q) - EDGE_W'(fld[1]);
    st1_d.s.z  = EDGE_W'(org_z_q) - EDGE_W'(fld[2]);
  end

  // round one: p = dir x e2, q = s x e1
  always_comb begin
    m1_a[0]  = MA_W'(st1_q.e2.z); m1_b[0]  = MB_W'(dir_y_q);
    m1_a[1]  = MA_W'(st1_q.e2.y); m1_b[1]  = MB_W'(dir_z_q);
    m1_a[2]  = MA_W'(st1_q.e2.x); m1_b[2]  = MB_W'(dir_z_q);
    m1_a[3]  = MA_W'(st1_q.e2.z); m1_b[3]  = MB_W'(dir_x_q);
    m1_a[4]  = MA_W'(st1_q.e2.y); m1_b[4]  = MB_W'(dir_x_q);
    m1_a[5]  = MA_W'(st1_q.e2.x); m1_b[5]  = MB_W'(dir_y_q);
    m1_a[6]  = MA_W'(st1_q.e1.z); m1_b[6]  = MB_W'(st1_q.s.y);
    m1_a[7]  = MA_W'(st1_q.e1.y); m1_b[7]  = MB_W'(st1_q.s.z);
    m1_a[8]  = MA_W'(st1_q.e1.x); m1_b[8]  = MB_W'(st1_q.s.z);
    m1_a[9]  = MA_W'(st1_q.e1.z); m1_b[9]  = MB_W'(st1_q.s.x);
    m1_a[10] = MA_W'(st1_q.e1.y); m1_b[10] = MB_W'(st1_q.s.x);
    m1_a[11] = MA_W'(st1_q.e1.x); m1_b[11] = MB_W'(st1_q.s.y);
  end

  // round two: det = e1.p, u = s.p, v = dir.q, t = e2.q
  always_comb begin
    m2_a[0]  = p_q.x; m2_b[0]  = MB_W'(xe_q.e1.x);
    m2_a[1]  = p_q.y; m2_b[1]  = MB_W'(xe_q.e1.y);
    m2_a[2]  = p_q.z; m2_b[2]  = MB_W'(xe_q.e1.z);
    m2_a[3]  = p_q.x; m2_b[3]  = MB_W'(xe_q.s.x);
    m2_a[4]  = p_q.y; m2_b[4]  = MB_W'(xe_q.s.y);
    m2_a[5]  = p_q.z; m2_b[5]  = MB_W'(xe_q.s.z);
    m2_a[6]  = q_q.x; m2_b[6]  = MB_W'(dir_x_q);
    m2_a[7]  = q_q.y; m2_b[7]  = MB_W'(dir_y_q);
    m2_a[8]  = q_q.z; m2_b[8]  = MB_W'(dir_z_q);
    m2_a[9]  = q_q.x; m2_b[9]  = MB_W'(xe_q.e2.x);
    m2_a[10] = q_q.y; m2_b[10] = MB_W'(xe_q.e2.y);
    m2_a[11] = q_q.z; m2_b[11] = MB_W'(xe_q.e2.z);
  end

  for (genvar m = 0; m < NMUL; m++) begin : g_mul
    rti_mul u_mul1 (.clk_i, .en_i(en), .a_i(m1_a[m]), .b_i(m1_b[m]), .p_o(m1_p[m]));
    rti_mul u_mul2 (.clk_i, .en_i(en), .a_i(m2_a[m]), .b_i(m2_b[m]), .p_o(m2_p[m]));
  end

  // sign normalisation
  always_comb begin
    det_s = det_q[DOT_W-1] ? -det_q : det_q;
    u_s   = det_q[DOT_W-1] ? -u_q   : u_q;
    v_s   = det_q[DOT_W-1] ? -v_q   : v_q;
    t_s   = det_q[DOT_W-1] ? -t_q   : t_q;
    det_x  = $signed({1'b0, DOT_W'(detn_q)});
    uv_sum = (DOT_W+1)'(un_q) + (DOT_W+1)'(vn_q);
    t_abs  = tn_q[DOT_W-1] ? DOT_W'(-tn_q) : DOT_W'(tn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v1d_q   <= '0;
      xv_q    <= 1'b0;
      v2d_q   <= '0;
      dv_q    <= 1'b0;
      nv_q    <= 1'b0;
      cv_q    <= 1'b0;
      div_v_q <= '0;
      res_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v1d_q   <= {v1d_q[MUL_LAT-2:0], v1_q};
      xv_q    <= v1d_q[MUL_LAT-1];
      v2d_q   <= {v2d_q[MUL_LAT-2:0], xv_q};
      dv_q    <= v2d_q[MUL_LAT-1];
      nv_q    <= dv_q;
      cv_q    <= nv_q;
      div_v_q <= {div_v_q[QUO_W-1:0], cv_q};
      res_v_q <= div_v_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q  <= st1_d;
      dly_q[0] <= st1_q;
      for (int i = 1; i < MUL_LAT; i++) dly_q[i] <= dly_q[i-1];
      p_q.x  <= MA_W'(m1_p[0]) - MA_W'(m1_p[1]);
      p_q.y  <= MA_W'(m1_p[2]) - MA_W'(m1_p[3]);
      p_q.z  <= MA_W'(m1_p[4]) - MA_W'(m1_p[5]);
      q_q.x  <= MA_W'(m1_p[6]) - MA_W'(m1_p[7]);
      q_q.y  <= MA_W'(m1_p[8]) - MA_W'(m1_p[9]);
      q_q.z  <= MA_W'(m1_p[10]) - MA_W'(m1_p[11]);
      xe_q   <= dly_q[MUL_LAT-1];
      det_q  <= m2_p[0] + m2_p[1] + m2_p[2];
      u_q    <= m2_p[3] + m2_p[4] + m2_p[5];
      v_q    <= m2_p[6] + m2_p[7] + m2_p[8];
      t_q    <= m2_p[9] + m2_p[10] + m2_p[11];
      detn_q <= DET_W'(det_s);
      un_q   <= u_s;
      vn_q   <= v_s;
      tn_q   <= t_s;
      par_miss_q <= $unsigned(det_s) <= DOT_W'(lim_q);
      c_miss_q <= par_miss_q || un_q[DOT_W-1] || vn_q[DOT_W-1]
                  || ((DOT_W+1)'(un_q) > det_x) || (uv_sum > det_x);
      c_tneg_q <= tn_q[DOT_W-1];
      c_num_q  <= NUM_W'(t_abs) << FRAC_W;
      c_det_q  <= detn_q;
    end
  end

  // quotient overflow check, then one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].miss <= c_miss_q;
      div_q[0].tneg <= c_tneg_q;
      div_q[0].ovf  <= DSH_W'(c_num_q) >= (DSH_W'(c_det_q) << QUO_W);
      div_q[0].rem  <= c_num_q;
      div_q[0].det  <= c_det_q;
      div_q[0].quo  <= '0;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_div
    localparam int K = QUO_W - i;
    logic [DSH_W-1:0] dsh;
    logic             ge;
    div_t             div_d;
    assign dsh = DSH_W'(div_q[i-1].det) << K;
    assign ge  = DSH_W'(div_q[i-1].rem) >= dsh;
    always_comb begin
      div_d = div_q[i-1];
      if (ge) div_d.rem = NUM_W'(DSH_W'(div_q[i-1].rem) - dsh);
      div_d.quo[K] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i] <= div_d;
      end
    end
  end

  assign div_last = div_q[QUO_W];

  always_comb begin
    if (div_last.miss) begin
      dist_d = MISS_DIST;
    end else if (div_last.tneg) begin
      dist_d = (div_last.ovf || div_last.quo > DIST_MIN) ? DIST_MIN : -div_last.quo;
    end else begin
      dist_d = (div_last.ovf || div_last.quo > DIST_MAX) ? DIST_MAX : div_last.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_hit_q  <= !div_last.miss;
      res_dist_q <= dist_d;
    end
  end

  // skid register: takes the result when the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) skid_v_q <= 1'b0;
    end else if (res_v_q && !m_axis_tready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_hit_q  <= res_hit_q;
      skid_dist_q <= res_dist_q;
    end
  end

  assign m_axis_tvalid = skid_v_q || res_v_q;
  assign m_axis_tuser  = skid_v_q ? skid_hit_q : res_hit_q;
  assign m_axis_tdata  = skid_v_q ? skid_dist_q : res_dist_q;

  a_miss_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == MISS_DIST))
    else $error("miss without -1.0 distance");

  a_skid_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(res_v_q && !m_axis_tready))
    else $error("skid loaded without a stalled result");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[QUO_W] && !div_last.miss && !div_last.ovf)
      |-> (DSH_W'(div_last.rem) < DSH_W'(div_last.det)))
    else $error("divider remainder not below divisor");

endmodule

FILE: src/rti_mul.sv
// Pipelined signed multiplier built from small partial products.
`timescale 1ns / 1ps
module rti_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [rti_pkg::MA_W-1:0]    a_i,
  input  logic signed [rti_pkg::MB_W-1:0]    b_i,
  output logic signed [rti_pkg::PROD_W-1:0]  p_o
);
  import rti_pkg::*;

  localparam int AM_W  = NCHUNK_A * CHUNK_A;
  localparam int BM_W  = NCHUNK_B * CHUNK_B;
  localparam int PP_W  = CHUNK_A + CHUNK_B;
  localparam int ROW_W = PP_W + CHUNK_B;
  localparam int MAG_W = PROD_W - 1;

  logic [MA_W-1:0]   a_abs;
  logic [MB_W-1:0]   b_abs;
  logic [AM_W-1:0]   am_q;
  logic [BM_W-1:0]   bm_q;
  logic [MUL_LAT-2:0] neg_q;
  logic [PP_W-1:0]   pp_q [NCHUNK_A][NCHUNK_B];
  logic [ROW_W-1:0]  row_q [NCHUNK_A];
  logic [MAG_W-1:0]  mag_d, mag_q;
  logic signed [PROD_W-1:0] p_q;

  assign a_abs = a_i[MA_W-1] ? MA_W'(-a_i) : MA_W'(a_i);
  assign b_abs = b_i[MB_W-1] ? MB_W'(-b_i) : MB_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q  <= AM_W'(a_abs);
      bm_q  <= BM_W'(b_abs);
      neg_q <= {neg_q[MUL_LAT-3:0], a_i[MA_W-1] ^ b_i[MB_W-1]};
    end
  end

  for (genvar i = 0; i < NCHUNK_A; i++) begin : g_row
    for (genvar j = 0; j < NCHUNK_B; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pp_q[i][j] <= PP_W'(am_q[i*CHUNK_A +: CHUNK_A]) * PP_W'(bm_q[j*CHUNK_B +: CHUNK_B]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row_q[i] <= ROW_W'(pp_q[i][0]) + (ROW_W'(pp_q[i][1]) << CHUNK_B);
      end
    end
  end

  always_comb begin
    mag_d = '0;
    for (int i = 0; i < NCHUNK_A; i++) begin
      mag_d = mag_d + (MAG_W'(row_q[i]) << (i * CHUNK_A));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      p_q   <= neg_q[MUL_LAT-2] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    end
  end

  assign p_o = p_q;

endmodule
